### design/assert_macros.svh
// assertion macros for the design files, used by the scheduler top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define SJF_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// condition holds in every cycle out of reset
`define SJF_ASSERT_ALWAYS(label, clk, rst_n, a) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
    else $error("assertion failed");

`endif

### design/sjf_pkg.sv
// types and constants for the shortest-job-first scheduler
// no dependencies
package sjf_pkg;

  localparam int unsigned TIME_W = 21;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned OIDX_W = 4;

  // best candidate seen so far, handed from cell to cell
  typedef struct packed {
    logic              found;
    logic              arrived;
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  run;
  } sjf_cand_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              wr;
    logic              mark;
    logic              clear;
    logic [TIME_W-1:0] now;
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  run;
  } sjf_ctrl_t;

endpackage

### design/sjf_if.sv
// valid/ready channel interfaces for job input and schedule output
// depends on sjf_pkg
interface sjf_in_if;
  logic                      valid;
  logic                      ready;
  logic [sjf_pkg::VAL_W-1:0] arrival_time;
  logic [sjf_pkg::VAL_W-1:0] run_time;
  logic                      last_job;
  modport source (output valid, arrival_time, run_time, last_job, input ready);
  modport sink   (input valid, arrival_time, run_time, last_job, output ready);
endinterface

interface sjf_out_if;
  logic                       valid;
  logic                       ready;
  logic [sjf_pkg::OIDX_W-1:0] job_index;
  logic [sjf_pkg::TIME_W-1:0] start_time;
  logic                       final_result;
  logic                       overflowed;
  modport source (output valid, job_index, start_time, final_result, overflowed,
                  input ready);
  modport sink   (input valid, job_index, start_time, final_result, overflowed,
                  output ready);
endinterface

### design/shortest_job_first_scheduler_top.sv
// channel   dir  payload                                            transfer
// in_i      in   arrival_time, run_time, last_job                   valid & ready
// out_o     out  job_index, start_time, final_result, overflowed    valid & ready
//
// jobs load in one cycle each; the item with last_job starts scheduling
// each result needs one pass of a token down the chain of MAX_JOBS cells plus launch and emit
// no input is taken while a set is being scheduled; output stalls hold the sequencer
// asynchronous active-low reset empties the set; job storage has no reset
// depends on sjf_pkg, sjf_if, sjf_cell and assert_macros.svh
`include "assert_macros.svh"
module shortest_job_first_scheduler_top #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sjf_in_if.sink    in_i,
  sjf_out_if.source out_o
);
  import sjf_pkg::*;

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [1:0] {S_LOAD, S_SCAN, S_EMIT} state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q, round_q;
  logic              ovf_q, launch_q;
  logic [TIME_W-1:0] time_q;
  sjf_cand_t         best_q;
  logic [IW-1:0]     best_idx_q;

  logic              out_vld_q, out_fin_q, out_ovf_q;
  logic [IW-1:0]     out_idx_q;
  logic [TIME_W-1:0] out_start_q;

  sjf_ctrl_t         ctrl;
  logic              in_xfer, emit, last_round;
  logic [TIME_W-1:0] start;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] next_time;

  logic      [MAX_JOBS:0] vld_chain;
  sjf_cand_t              cand_chain [MAX_JOBS+1];
  logic [IW-1:0]          idx_chain  [MAX_JOBS+1];

  // handshakes and start-time arithmetic
  assign in_i.ready = (state_q == S_LOAD);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign emit       = (state_q == S_EMIT) && (!out_vld_q || out_o.ready);
  assign last_round = (round_q == count_q - CW'(1));
  assign start      = (time_q < {{(TIME_W-VAL_W){1'b0}}, best_q.arr}) ?
                      {{(TIME_W-VAL_W){1'b0}}, best_q.arr} : time_q;
  assign sum        = {1'b0, start} + {{(TIME_W+1-VAL_W){1'b0}}, best_q.run};
  assign next_time  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  // broadcast control
  always_comb begin
    ctrl.wr    = in_xfer && (count_q < CW'(MAX_JOBS));
    ctrl.mark  = emit;
    ctrl.clear = emit && last_round;
    ctrl.now   = time_q;
    ctrl.arr   = in_i.arrival_time;
    ctrl.run   = in_i.run_time;
  end

  // chain head: empty candidate following the launch token
  assign vld_chain[0]  = launch_q;
  assign cand_chain[0] = '0;
  assign idx_chain[0]  = '0;

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    sjf_cell #(.IDX(k), .IW(IW), .CW(CW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_idx_i   (count_q[IW-1:0]),
      .mark_idx_i (best_idx_q),
      .count_i    (count_q),
      .vld_i      (vld_chain[k]),
      .cand_i     (cand_chain[k]),
      .idx_i      (idx_chain[k]),
      .vld_o      (vld_chain[k+1]),
      .cand_o     (cand_chain[k+1]),
      .idx_o      (idx_chain[k+1])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      count_q    <= '0;
      round_q    <= '0;
      ovf_q      <= 1'b0;
      launch_q   <= 1'b0;
      time_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      launch_q <= (in_xfer && in_i.last_job) || (emit && !last_round);
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            if (count_q < CW'(MAX_JOBS)) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.last_job) begin
              state_q  <= S_SCAN;
              round_q  <= '0;
              time_q   <= '0;
            end
          end
        end
        S_SCAN: begin
          if (vld_chain[MAX_JOBS]) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            if (last_round) begin
              state_q <= S_LOAD;
              count_q <= '0;
              ovf_q   <= 1'b0;
              time_q  <= '0;
            end else begin
              state_q  <= S_SCAN;
              round_q  <= round_q + CW'(1);
              time_q   <= next_time;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && vld_chain[MAX_JOBS]) begin
      best_q     <= cand_chain[MAX_JOBS];
      best_idx_q <= idx_chain[MAX_JOBS];
    end
    if (emit) begin
      out_idx_q   <= best_idx_q;
      out_start_q <= start;
      out_fin_q   <= last_round;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.job_index    = OIDX_W'(out_idx_q);
  assign out_o.start_time   = out_start_q;
  assign out_o.final_result = out_fin_q;
  assign out_o.overflowed   = out_ovf_q;

  // checks
  `SJF_ASSERT_IMP(a_launch_scan, clk_i, rst_ni, launch_q, state_q == S_SCAN)
  `SJF_ASSERT_IMP(a_token_scan, clk_i, rst_ni, vld_chain[MAX_JOBS], state_q == S_SCAN)
  `SJF_ASSERT_ALWAYS(a_one_token, clk_i, rst_ni, $onehot0(vld_chain))
  `SJF_ASSERT_ALWAYS(a_count_cap, clk_i, rst_ni, count_q <= CW'(MAX_JOBS))

endmodule

### design/sjf_cell.sv
// one job slot of the scan chain: holds a job and folds it into the passing candidate
// depends on sjf_pkg
module sjf_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4,
  parameter int unsigned CW  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sjf_pkg::sjf_ctrl_t ctrl_i,
  input  logic [IW-1:0]      wr_idx_i,
  input  logic [IW-1:0]      mark_idx_i,
  input  logic [CW-1:0]      count_i,
  input  logic               vld_i,
  input  sjf_pkg::sjf_cand_t cand_i,
  input  logic [IW-1:0]      idx_i,
  output logic               vld_o,
  output sjf_pkg::sjf_cand_t cand_o,
  output logic [IW-1:0]      idx_o
);
  import sjf_pkg::*;

  logic [VAL_W-1:0] arr_q, run_q;
  logic             fin_q;
  logic             elig, arrived, take;
  sjf_cand_t        cand_d, mine;
  logic [IW-1:0]    idx_d;

  // job storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && wr_idx_i == IW'(IDX)) begin
      arr_q <= ctrl_i.arr;
      run_q <= ctrl_i.run;
    end
  end

  // finished mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      fin_q <= 1'b0;
    end else if (ctrl_i.wr && wr_idx_i == IW'(IDX)) begin
      fin_q <= 1'b0;
    end else if (ctrl_i.mark && mark_idx_i == IW'(IDX)) begin
      fin_q <= 1'b1;
    end
  end

  // compare own job against the incoming candidate
  always_comb begin
    elig    = (CW'(IDX) < count_i) && !fin_q;
    arrived = {{(TIME_W-VAL_W){1'b0}}, arr_q} <= ctrl_i.now;
    mine    = '{found: 1'b1, arrived: arrived, arr: arr_q, run: run_q};
    take    = 1'b0;
    if (elig) begin
      if (!cand_i.found) begin
        take = 1'b1;
      end else if (arrived != cand_i.arrived) begin
        take = arrived;
      end else if (arrived) begin
        take = run_q < cand_i.run;
      end else begin
        take = (arr_q < cand_i.arr) || (arr_q == cand_i.arr && run_q < cand_i.run);
      end
    end
    cand_d = take ? mine : cand_i;
    idx_d  = take ? IW'(IDX) : idx_i;
  end

  // hand on to the neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_o <= cand_d;
    idx_o  <= idx_d;
  end

endmodule

### sim/tb_sjf_scoreboard.sv
`timescale 1ns / 100ps
// scoreboard for the shortest-job-first scheduler: predicts the schedule of each job set
// depends on sjf_pkg
package tb_sjf_sb_pkg;
  import sjf_pkg::*;

  typedef struct packed {
    logic [OIDX_W-1:0] job_index;
    logic [TIME_W-1:0] start_time;
    logic              final_result;
    logic              overflowed;
  } sched_slot_t;

  class sjf_scoreboard;
    int unsigned       cap;
    logic [VAL_W-1:0]  arr_q[$];
    logic [VAL_W-1:0]  run_q[$];
    bit                dropped;
    sched_slot_t       pending_q[$];
    int unsigned       n_fail;
    int unsigned       n_checked;
    int unsigned       n_sets;
    int unsigned       n_dropped;

    function new(int unsigned max_jobs);
      cap = max_jobs;
    endfunction

    // note an accepted job, and on the last one work out the whole schedule
    function void note_job(logic [VAL_W-1:0] arr, logic [VAL_W-1:0] run, bit last);
      bit           done[$];
      int           best;
      bit           found;
      logic [21:0]  now;
      int unsigned  n;
      sched_slot_t  s;
      if (arr_q.size() < cap) begin
        arr_q.push_back(arr);
        run_q.push_back(run);
      end else begin
        dropped = 1'b1;
        n_dropped++;
      end
      if (!last) return;
      n = arr_q.size();
      for (int k = 0; k < n; k++) done.push_back(1'b0);
      now = '0;
      for (int r = 0; r < n; r++) begin
        found = 1'b0;
        best = 0;
        // shortest run among jobs already arrived
        for (int k = 0; k < n; k++) begin
          if (!done[k] && arr_q[k] <= now && (!found || run_q[k] < run_q[best])) begin
            best = k;
            found = 1'b1;
          end
        end
        // otherwise earliest arrival, then shorter run
        if (!found) begin
          for (int k = 0; k < n; k++) begin
            if (!done[k] && (!found || arr_q[k] < arr_q[best] ||
                (arr_q[k] == arr_q[best] && run_q[k] < run_q[best]))) begin
              best = k;
              found = 1'b1;
            end
          end
        end
        done[best] = 1'b1;
        if (now < arr_q[best]) now = arr_q[best];
        s.job_index    = best[OIDX_W-1:0];
        s.start_time   = now[TIME_W-1:0];
        s.final_result = (r + 1 == n);
        s.overflowed   = dropped;
        pending_q.push_back(s);
        now = now + run_q[best];
        if (now > 22'h1FFFFF) now = 22'h1FFFFF;
      end
      arr_q.delete();
      run_q.delete();
      dropped = 1'b0;
      n_sets++;
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_slot(sched_slot_t got);
      sched_slot_t exp_s;
      if (pending_q.size() == 0) begin
        $error("unexpected result job_index=%0d start_time=%0d", got.job_index,
               got.start_time);
        n_fail++;
        return;
      end
      exp_s = pending_q.pop_front();
      n_checked++;
      if (got.job_index !== exp_s.job_index) begin
        $error("job_index expected %0d actual %0d", exp_s.job_index, got.job_index);
        n_fail++;
      end
      if (got.start_time !== exp_s.start_time) begin
        $error("start_time expected %0d actual %0d", exp_s.start_time, got.start_time);
        n_fail++;
      end
      if (got.final_result !== exp_s.final_result) begin
        $error("final_result expected %0b actual %0b", exp_s.final_result,
               got.final_result);
        n_fail++;
      end
      if (got.overflowed !== exp_s.overflowed) begin
        $error("overflowed expected %0b actual %0b", exp_s.overflowed, got.overflowed);
        n_fail++;
      end
    endfunction
  endclass
endpackage

### sim/tb_shortest_job_first_scheduler_top.sv
`timescale 1ns / 100ps
// testbench for shortest_job_first_scheduler_top: random job sets, idling phases
// depends on sjf_pkg, sjf_if, tb_sjf_sb_pkg and the design
module tb_shortest_job_first_scheduler_top;
  import sjf_pkg::*;
  import tb_sjf_sb_pkg::*;

  localparam int unsigned JOBS      = 16;
  localparam int unsigned WD_LIMIT  = 20000;
  localparam int unsigned N_RANDOM  = 460;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  int   n_items = 0;
  bit   timed_out = 1'b0;
  int unsigned idle_count = 0;

  sjf_in_if  in_ch ();
  sjf_out_if out_ch ();

  sjf_scoreboard sched_sb = new(JOBS);

  shortest_job_first_scheduler_top #(.MAX_JOBS(JOBS)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.arrival_time = '0;
    in_ch.run_time = '0;
    in_ch.last_job = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, check on each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sched_sb.check_slot('{out_ch.job_index, out_ch.start_time, out_ch.final_result,
                              out_ch.overflowed});
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WD_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
        $display("shortest_job_first_scheduler_top regression: fail");
        $finish;
      end
    end
  end

  // one job transfer, with random idle cycles before it
  task automatic send_job(logic [VAL_W-1:0] arr, logic [VAL_W-1:0] run, bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.arrival_time <= arr;
    in_ch.run_time     <= run;
    in_ch.last_job     <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sched_sb.note_job(arr, run, last);
    n_items++;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(4))
      0: return '0;
      1: return 16'hFFFF;
      2: return VAL_W'($urandom_range(15));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // a random set; now and then longer than capacity
  task automatic send_set();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(JOBS + 1, JOBS + 4)
                                 : $urandom_range(1, 6);
    for (int k = 0; k < n; k++) send_job(rand_val(), rand_val(), k == n - 1);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single jobs at the extremes
    send_job(16'h0000, 16'h0000, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    // equal run times and equal arrivals, ties go to the lower index
    send_job(16'd5, 16'd3, 1'b0);
    send_job(16'd5, 16'd3, 1'b0);
    send_job(16'd0, 16'd9, 1'b1);
    // nothing arrived yet: time jumps to the earliest arrival
    send_job(16'd900, 16'd7, 1'b0);
    send_job(16'd100, 16'd50, 1'b0);
    send_job(16'd100, 16'd20, 1'b1);
    // overfull set: only the last item, which ends the set, is dropped; long runs push time high
    for (int k = 0; k <= JOBS; k++)
      send_job(16'd0, 16'hFFFF - k[15:0], k == JOBS);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 14; snk_stall_pct = 14; end
      endcase
      while (n_items < 25 + (ph + 1) * N_RANDOM / 4) send_set();
    end
    in_ch.valid <= 1'b0;

    while (sched_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4 * JOBS) @(posedge clk_i);

    $display("ran %0d jobs in %0d sets, %0d results checked, %0d jobs over capacity",
             n_items, sched_sb.n_sets, sched_sb.n_checked, sched_sb.n_dropped);
    if (sched_sb.n_fail == 0 && sched_sb.pending_q.size() == 0)
      $display("shortest_job_first_scheduler_top regression: pass");
    else
      $display("shortest_job_first_scheduler_top regression: fail");
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/sjf_pkg.sv
design/sjf_if.sv
design/sjf_cell.sv
design/shortest_job_first_scheduler_top.sv
sim/tb_sjf_scoreboard.sv
sim/tb_shortest_job_first_scheduler_top.sv
